// ----- src/task_scheduler_fifo_rr_sjf_unit_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef TASK_SCHEDULER_FIFO_RR_SJF_UNIT_MACROS_SVH
`define TASK_SCHEDULER_FIFO_RR_SJF_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSFRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define TSFRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ----- src/tsfrs_pkg.sv -----
// Types and constants of the task scheduler.
package tsfrs_pkg;

  localparam int BW = 24;
  localparam logic [BW-1:0] BURST_MAX = 24'hFFFFFF;
  localparam logic [8:0] ALPHA_ONE = 9'd256;

  // Task status codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_EXIT    = 2'd3;

  // Event codes
  localparam logic [1:0] FN_READY = 2'd0;
  localparam logic [1:0] FN_TICK  = 2'd1;
  localparam logic [1:0] FN_BLOCK = 2'd2;
  localparam logic [1:0] FN_EXIT  = 2'd3;

  // Scheduling modes
  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_RR   = 2'd1;
  localparam logic [1:0] MODE_SJF  = 2'd2;
  localparam logic [1:0] MODE_SJFP = 2'd3;

  // Configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_QUANTUM  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ALPHA    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INIT_EST = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_NTASKS   = 3'd4;

  // One task record in the task memory
  typedef struct packed {
    logic [BW-1:0] cached;
    logic [BW-1:0] actual;
    logic [BW-1:0] predicted;
  } task_entry_t;

endpackage

// ----- src/tsfrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsfrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tsfrs_est.sv -----
// Two-stage exponential burst average: (a*actual + (256-a)*predicted + 128) >> 8.
module tsfrs_est import tsfrs_pkg::*; (
  input  logic          clk,
  input  logic [8:0]    alpha_w,
  input  logic [BW-1:0] act,
  input  logic [BW-1:0] pred,
  output logic [BW-1:0] res
);

  logic [BW+8:0] p_a;
  logic [BW+8:0] p_b;
  logic [BW+9:0] sum;
  logic [BW+1:0] shifted;

  // Stage one: the two weighted products
  always_ff @(posedge clk) begin
    p_a <= (BW+9)'(alpha_w) * (BW+9)'(act);
    p_b <= (BW+9)'(ALPHA_ONE - alpha_w) * (BW+9)'(pred);
  end

  // Round half up, drop the fraction of the weight, saturate
  assign sum     = (BW+10)'(p_a) + (BW+10)'(p_b) + (BW+10)'(128);
  assign shifted = sum[BW+9:8];

  always_ff @(posedge clk) begin
    res <= (shifted > (BW+2)'(BURST_MAX)) ? BURST_MAX : shifted[BW-1:0];
  end

endmodule

// ----- src/task_scheduler_fifo_rr_sjf_unit.sv -----
// Single-runner task scheduler (FIFO, round robin, SJF, preemptive SJF), one result per event.
// Each event is taken alone and runs through a sequencer around two memories: a ready queue
// of task ids and a task memory of predicted, actual and cached burst. A FIFO or round-robin
// dispatch takes the chosen entry and shifts the queue entries behind it forward one per cycle.
// SJF selection reads the estimate of each ready entry, using the cached one where it is valid
// and else computing it with the two-stage multiplier and caching it. The result is held in an
// output register, and the next item is taken once the sequencer is back at rest.
module task_scheduler_fifo_rr_sjf_unit import tsfrs_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [3:0]        task_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              running_valid,
  output logic [3:0]        running_task,
  output logic              dispatched,
  output logic              preempted,
  output logic [3:0]        preempted_task,
  output logic              all_exited,
  output logic              rejected,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [BW-1:0]     cfg_data
);

  `include "task_scheduler_fifo_rr_sjf_unit_macros.svh"

  localparam int TW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = $bits(task_entry_t);
  localparam logic [BW-1:0] TICK_INC = BW'(64'd1 << FRAC_BITS);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_TASKS);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_EXEC      = 5'd1;
  localparam logic [4:0] S_TICK_W    = 5'd2;
  localparam logic [4:0] S_DISPATCH  = 5'd3;
  localparam logic [4:0] S_SCAN_Q    = 5'd4;
  localparam logic [4:0] S_SCAN_T    = 5'd5;
  localparam logic [4:0] S_SCAN_E    = 5'd6;
  localparam logic [4:0] S_SCAN_W1   = 5'd7;
  localparam logic [4:0] S_SCAN_W2   = 5'd8;
  localparam logic [4:0] S_PICK_DONE = 5'd9;
  localparam logic [4:0] S_PRE_PUSH  = 5'd10;
  localparam logic [4:0] S_RR_PUSH   = 5'd11;
  localparam logic [4:0] S_TAKE0     = 5'd12;
  localparam logic [4:0] S_TAKE1     = 5'd13;
  localparam logic [4:0] S_SHIFT     = 5'd14;
  localparam logic [4:0] S_DISP      = 5'd15;
  localparam logic [4:0] S_FINISH    = 5'd16;

  logic [4:0]  state;

  // Configuration registers
  logic [1:0]    mode;
  logic [7:0]    quantum;
  logic [8:0]    alpha;
  logic [BW-1:0] init_est;
  logic [4:0]    num_tasks;

  // Per-task flags in flops
  logic [1:0]           status [MAX_TASKS];
  logic [MAX_TASKS-1:0] est_valid;
  logic [MAX_TASKS-1:0] pred_init;
  logic [MAX_TASKS-1:0] act_zero;

  // Scheduler state
  logic [CW-1:0] count;
  logic          run_valid;
  logic [TW-1:0] runner;
  logic [7:0]    qused;

  // Event context
  logic [1:0]    ev_func;
  logic [TW-1:0] ev_tid;
  logic          ev_tid_ok;
  logic          disp;
  logic          pre;
  logic          rej;
  logic [TW-1:0] pre_task;
  logic          chk;

  // Scan and take context
  logic [CW-1:0] scan_i;
  logic [CW-1:0] best_pos;
  logic [BW-1:0] best_est;
  logic [TW-1:0] cur_tid;
  logic [BW-1:0] sa;
  logic [BW-1:0] sp;
  logic [BW-1:0] run_act;
  logic [BW-1:0] run_pred;
  logic [BW-1:0] rem;
  logic [CW-1:0] take_j;
  logic [TW-1:0] take_tid;

  // Memory ports
  logic          q_we;
  logic [TW-1:0] q_waddr;
  logic [TW-1:0] q_wdata;
  logic [TW-1:0] q_raddr;
  logic [TW-1:0] q_rdata;
  logic          t_we;
  logic [TW-1:0] t_waddr;
  task_entry_t   t_wdata;
  logic [TW-1:0] t_raddr;
  logic [EW-1:0] t_rdata;
  task_entry_t   t_rd;

  // Derived values
  logic [TW-1:0] rd_tid;
  logic [BW-1:0] eff_act;
  logic [BW-1:0] eff_pred;
  logic [BW-1:0] new_act;
  logic [BW-1:0] tick_rem;
  logic [7:0]    qn;
  logic [7:0]    q_eff;
  logic [8:0]    alpha_eff;
  logic [BW-1:0] est_res;
  logic [BW-1:0] scan_e;
  logic          scan_better;
  logic          scan_last;
  logic          rdy_ok;
  logic          sjf;
  logic          all_now;

  tsfrs_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  tsfrs_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_tasks (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );

  tsfrs_est u_est (
    .clk(clk), .alpha_w(alpha_eff), .act(eff_act), .pred(eff_pred), .res(est_res)
  );

  assign in_ready  = (state == S_IDLE);
  // Accept register writes only while no event is in flight
  assign cfg_ready = (state == S_IDLE);
  assign t_rd      = task_entry_t'(t_rdata);
  assign sjf       = (mode == MODE_SJF) || (mode == MODE_SJFP);
  assign alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign q_eff     = (quantum == 8'd0) ? 8'd1 : quantum;
  assign qn        = (qused != 8'hFF) ? qused + 8'd1 : qused;

  // Effective burst values of the entry just read
  assign rd_tid   = (state == S_TICK_W) ? runner : cur_tid;
  assign eff_act  = act_zero[rd_tid] ? '0 : t_rd.actual;
  assign eff_pred = pred_init[rd_tid] ? init_est : t_rd.predicted;
  assign new_act  = (eff_act > BURST_MAX - TICK_INC) ? BURST_MAX : eff_act + TICK_INC;
  assign tick_rem = (eff_pred > new_act) ? eff_pred - new_act : '0;

  // Minimum search step
  assign scan_e      = (state == S_SCAN_W2) ? est_res : t_rd.cached;
  assign scan_better = (scan_i == '0) || (scan_e < best_est);
  assign scan_last   = (CW'(scan_i + CW'(1)) >= count);

  assign rdy_ok = ev_tid_ok && ((status[ev_tid] == ST_IDLE) || (status[ev_tid] == ST_BLOCKED));

  // Every task in use has exited
  always_comb begin
    all_now = 1'b1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if ((i < int'(num_tasks)) && (status[i] != ST_EXIT)) begin
        all_now = 1'b0;
      end
    end
  end

  // Drive memory ports from the sequencer
  always_comb begin
    q_we    = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    q_raddr = '0;
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    case (state)
      S_EXEC: begin
        if ((ev_func == FN_READY) && rdy_ok && (count < COUNT_FULL)) begin
          q_we    = 1'b1;
          q_waddr = count[TW-1:0];
          q_wdata = ev_tid;
        end
        t_raddr = runner;
      end
      S_TICK_W: begin
        t_we    = 1'b1;
        t_waddr = runner;
        t_wdata = '{cached: t_rd.cached, actual: new_act, predicted: eff_pred};
      end
      S_RR_PUSH: begin
        q_we    = (count < COUNT_FULL);
        q_waddr = count[TW-1:0];
        q_wdata = runner;
      end
      S_SCAN_Q: begin
        q_raddr = scan_i[TW-1:0];
      end
      S_SCAN_T: begin
        t_raddr = q_rdata;
      end
      S_SCAN_W2: begin
        t_we    = 1'b1;
        t_waddr = cur_tid;
        t_wdata = '{cached: est_res, actual: sa, predicted: sp};
      end
      S_PRE_PUSH: begin
        q_we    = (count < COUNT_FULL);
        q_waddr = count[TW-1:0];
        q_wdata = runner;
        t_we    = 1'b1;
        t_waddr = runner;
        t_wdata = '{cached: rem, actual: run_act, predicted: run_pred};
      end
      S_TAKE0: begin
        q_raddr = best_pos[TW-1:0];
      end
      S_TAKE1: begin
        q_raddr = TW'(best_pos + CW'(1));
      end
      S_SHIFT: begin
        q_we    = 1'b1;
        q_waddr = take_j[TW-1:0];
        q_wdata = q_rdata;
        q_raddr = TW'(take_j + CW'(2));
      end
      S_DISP: begin
        t_we    = sjf;
        t_waddr = take_tid;
        t_wdata = '{cached: '0, actual: '0, predicted: best_est};
      end
      default: begin
      end
    endcase
  end

  // Sequencer, per-task flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_FIFO;
      quantum   <= 8'd4;
      alpha     <= 9'd128;
      init_est  <= 24'd1280;
      num_tasks <= 5'd16;
      for (int i = 0; i < MAX_TASKS; i++) begin
        status[i] <= ST_IDLE;
      end
      est_valid <= '0;
      pred_init <= '1;
      act_zero  <= '1;
      count     <= '0;
      run_valid <= 1'b0;
      runner    <= '0;
      qused     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ev_func   <= func;
            ev_tid    <= TW'(task_id);
            ev_tid_ok <= (int'(task_id) < MAX_TASKS);
            disp      <= 1'b0;
            pre       <= 1'b0;
            rej       <= 1'b0;
            pre_task  <= '0;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ev_func == FN_READY) begin
            if (!rdy_ok) begin
              rej   <= 1'b1;
              state <= S_FINISH;
            end else begin
              status[ev_tid] <= ST_READY;
              if (count < COUNT_FULL) begin
                count <= count + CW'(1);
              end
              state <= run_valid ? S_FINISH : S_DISPATCH;
            end
          end else if (!run_valid) begin
            rej   <= 1'b1;
            state <= S_FINISH;
          end else if (ev_func == FN_TICK) begin
            state <= S_TICK_W;
          end else begin
            status[runner] <= (ev_func == FN_BLOCK) ? ST_BLOCKED : ST_EXIT;
            run_valid      <= 1'b0;
            state          <= S_DISPATCH;
          end
        end
        S_TICK_W: begin
          act_zero[runner]  <= 1'b0;
          pred_init[runner] <= 1'b0;
          run_act           <= new_act;
          run_pred          <= eff_pred;
          rem               <= tick_rem;
          if (mode == MODE_RR) begin
            qused <= qn;
            if (qn >= q_eff) begin
              pre      <= 1'b1;
              pre_task <= runner;
              state    <= S_RR_PUSH;
            end else begin
              state <= S_FINISH;
            end
          end else if ((mode == MODE_SJFP) && (count != '0)) begin
            chk    <= 1'b1;
            scan_i <= '0;
            state  <= S_SCAN_Q;
          end else begin
            state <= S_FINISH;
          end
        end
        S_RR_PUSH: begin
          if (count < COUNT_FULL) begin
            count <= count + CW'(1);
          end
          run_valid <= 1'b0;
          state     <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (count == '0) begin
            state <= S_FINISH;
          end else if (sjf) begin
            chk    <= 1'b0;
            scan_i <= '0;
            state  <= S_SCAN_Q;
          end else begin
            best_pos <= '0;
            state    <= S_TAKE0;
          end
        end
        S_SCAN_Q: begin
          state <= S_SCAN_T;
        end
        S_SCAN_T: begin
          cur_tid <= q_rdata;
          state   <= S_SCAN_E;
        end
        S_SCAN_E, S_SCAN_W2: begin
          if ((state == S_SCAN_E) && !est_valid[cur_tid]) begin
            // compute the estimate, then cache it
            sa    <= eff_act;
            sp    <= eff_pred;
            state <= S_SCAN_W1;
          end else begin
            if (state == S_SCAN_W2) begin
              est_valid[cur_tid] <= 1'b1;
              act_zero[cur_tid]  <= 1'b0;
              pred_init[cur_tid] <= 1'b0;
            end
            if (scan_better) begin
              best_est <= scan_e;
              best_pos <= scan_i;
            end
            if (scan_last) begin
              state <= S_PICK_DONE;
            end else begin
              scan_i <= scan_i + CW'(1);
              state  <= S_SCAN_Q;
            end
          end
        end
        S_SCAN_W1: begin
          state <= S_SCAN_W2;
        end
        S_PICK_DONE: begin
          if (!chk) begin
            state <= S_TAKE0;
          end else if (best_est < rem) begin
            pre      <= 1'b1;
            pre_task <= runner;
            state    <= S_PRE_PUSH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_PRE_PUSH: begin
          if (count < COUNT_FULL) begin
            count <= count + CW'(1);
          end
          est_valid[runner] <= 1'b1;
          act_zero[runner]  <= 1'b0;
          pred_init[runner] <= 1'b0;
          state             <= S_TAKE0;
        end
        S_TAKE0: begin
          state <= S_TAKE1;
        end
        S_TAKE1: begin
          take_tid <= q_rdata;
          take_j   <= best_pos;
          count    <= count - CW'(1);
          state    <= (CW'(best_pos + CW'(1)) < count) ? S_SHIFT : S_DISP;
        end
        S_SHIFT: begin
          // close the gap one entry a cycle
          take_j <= take_j + CW'(1);
          if (!(CW'(take_j + CW'(1)) < count)) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          act_zero[take_tid] <= 1'b1;
          if (sjf) begin
            pred_init[take_tid] <= 1'b0;
            est_valid[take_tid] <= 1'b0;
          end
          runner    <= take_tid;
          run_valid <= 1'b1;
          qused     <= '0;
          disp      <= 1'b1;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            running_valid  <= run_valid;
            running_task   <= run_valid ? 4'(runner) : 4'd0;
            dispatched     <= disp;
            preempted      <= pre;
            preempted_task <= pre ? 4'(pre_task) : 4'd0;
            all_exited     <= all_now;
            rejected       <= rej;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:     mode      <= cfg_data[1:0];
          CFG_QUANTUM:  quantum   <= cfg_data[7:0];
          CFG_ALPHA:    alpha     <= cfg_data[8:0];
          CFG_INIT_EST: begin
            init_est  <= cfg_data;
            pred_init <= '1;
            est_valid <= '0;
          end
          CFG_NTASKS:   num_tasks <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  `TSFRS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, state != S_IDLE)
  `TSFRS_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1, count <= COUNT_FULL)
  `TSFRS_ASSERT_NOW(a_dispatch_has_runner, clk, rst, out_valid && dispatched, running_valid)
  `TSFRS_ASSERT_NEXT(a_finish_loads_result, clk, rst, (state == S_FINISH) && (!out_valid || out_ready), out_valid)

endmodule

// ----- tb/sv/tsfrs_checker.sv -----
// Scoreboard for the task scheduler: mirrors its state, predicts each result and compares.
module tsfrs_checker import tsfrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        func,
  input  logic [3:0]        task_id,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              running_valid,
  input  logic [3:0]        running_task,
  input  logic              dispatched,
  input  logic              preempted,
  input  logic [3:0]        preempted_task,
  input  logic              all_exited,
  input  logic              rejected,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [BW-1:0]     cfg_data,
  output int                pending,
  output int                errors
);

  localparam int NT = 16;

  typedef struct packed {
    logic       run_v;
    logic [3:0] run_t;
    logic       disp;
    logic       pre;
    logic [3:0] pre_t;
    logic       all;
    logic       rej;
  } sched_result_t;

  // Shadow configuration
  logic [1:0]    mode_q;
  logic [7:0]    quantum_q;
  logic [8:0]    alpha_q;
  logic [BW-1:0] init_est_q;
  logic [4:0]    ntasks_q;

  // Shadow scheduler state
  logic [3:0]    ready_q[$];
  logic [1:0]    status[NT];
  logic [BW-1:0] pred_burst[NT];
  logic [BW-1:0] act_burst[NT];
  logic [BW-1:0] est_cache[NT];
  bit            est_ok[NT];
  bit            run_v;
  logic [3:0]    runner;
  int            q_used;

  sched_result_t expected_results[$];

  assign pending = expected_results.size();

  // Exponential average of a task's burst, cached until its dispatch or an initial-estimate write
  function automatic logic [BW-1:0] burst_estimate(int t);
    longint unsigned a, v;
    if (!est_ok[t]) begin
      a = (alpha_q > ALPHA_ONE) ? 256 : alpha_q;
      v = a * act_burst[t] + (256 - a) * pred_burst[t] + 128;
      v = v >> 8;
      if (v > BURST_MAX) v = BURST_MAX;
      est_cache[t] = v[BW-1:0];
      est_ok[t] = 1;
    end
    return est_cache[t];
  endfunction

  // Queue position of the smallest estimate; earliest entry wins ties
  function automatic int shortest_pos(output logic [BW-1:0] best);
    int pos;
    logic [BW-1:0] e;
    pos = 0;
    best = burst_estimate(ready_q[0]);
    for (int i = 1; i < ready_q.size(); i++) begin
      e = burst_estimate(ready_q[i]);
      if (e < best) begin
        best = e;
        pos = i;
      end
    end
    return pos;
  endfunction

  function automatic void enqueue_task(logic [3:0] t);
    if (ready_q.size() < NT) ready_q.push_back(t);
  endfunction

  // Start the next task (queue head or shortest), if any
  function automatic bit dispatch_next();
    int pos;
    logic [BW-1:0] e;
    logic [3:0] t;
    if (ready_q.size() == 0) return 0;
    pos = (mode_q >= MODE_SJF) ? shortest_pos(e) : 0;
    t = ready_q[pos];
    ready_q.delete(pos);
    if (mode_q >= MODE_SJF) begin
      pred_burst[t] = burst_estimate(t);
      est_ok[t] = 0;
    end
    act_burst[t] = '0;
    q_used = 0;
    runner = t;
    run_v = 1;
    return 1;
  endfunction

  function automatic sched_result_t schedule_event(logic [1:0] f, logic [3:0] tid);
    sched_result_t r;
    int q, n;
    logic [BW-1:0] rem, best;
    int pos;
    logic [3:0] t;
    r = '0;
    if (f == FN_READY) begin
      if (status[tid] != ST_IDLE && status[tid] != ST_BLOCKED) begin
        r.rej = 1;
      end else begin
        status[tid] = ST_READY;
        enqueue_task(tid);
        if (!run_v) r.disp = dispatch_next();
      end
    end else if (!run_v) begin
      r.rej = 1;
    end else if (f == FN_TICK) begin
      act_burst[runner] = (act_burst[runner] > BURST_MAX - 256) ? BURST_MAX
                                                                : act_burst[runner] + 256;
      if (mode_q == MODE_RR) begin
        q = (quantum_q == 0) ? 1 : quantum_q;
        if (q_used < 255) q_used++;
        if (q_used >= q) begin
          r.pre = 1;
          r.pre_t = runner;
          enqueue_task(runner);
          run_v = 0;
          r.disp = dispatch_next();
        end
      end else if (mode_q == MODE_SJFP && ready_q.size() > 0) begin
        rem = (pred_burst[runner] > act_burst[runner]) ?
              pred_burst[runner] - act_burst[runner] : '0;
        pos = shortest_pos(best);
        if (best < rem) begin
          est_cache[runner] = rem;
          est_ok[runner] = 1;
          r.pre = 1;
          r.pre_t = runner;
          enqueue_task(runner);
          t = ready_q[pos];
          ready_q.delete(pos);
          pred_burst[t] = burst_estimate(t);
          est_ok[t] = 0;
          act_burst[t] = '0;
          q_used = 0;
          runner = t;
          r.disp = 1;
        end
      end
    end else begin
      status[runner] = (f == FN_BLOCK) ? ST_BLOCKED : ST_EXIT;
      run_v = 0;
      r.disp = dispatch_next();
    end
    n = (ntasks_q > NT) ? NT : ntasks_q;
    r.all = 1;
    for (int i = 0; i < n; i++)
      if (status[i] != ST_EXIT) r.all = 0;
    r.run_v = run_v;
    r.run_t = run_v ? runner : 4'd0;
    return r;
  endfunction

  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0d actual %0d", $time, name, e, a);
    end
  endtask

  // Track config writes and items, compare each result with the oldest prediction
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst) begin
      errors = 0;
      mode_q = MODE_FIFO;
      quantum_q = 8'd4;
      alpha_q = 9'd128;
      init_est_q = 24'd1280;
      ntasks_q = 5'd16;
      ready_q.delete();
      for (int i = 0; i < NT; i++) begin
        status[i] = ST_IDLE;
        pred_burst[i] = 24'd1280;
        act_burst[i] = '0;
        est_cache[i] = '0;
        est_ok[i] = 0;
      end
      run_v = 0;
      runner = '0;
      q_used = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no item outstanding", $time);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("running_valid", exp_r.run_v, running_valid);
          check_field("running_task", exp_r.run_t, running_task);
          check_field("dispatched", exp_r.disp, dispatched);
          check_field("preempted", exp_r.pre, preempted);
          check_field("preempted_task", exp_r.pre_t, preempted_task);
          check_field("all_exited", exp_r.all, all_exited);
          check_field("rejected", exp_r.rej, rejected);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:    mode_q = cfg_data[1:0];
          CFG_QUANTUM: quantum_q = cfg_data[7:0];
          CFG_ALPHA:   alpha_q = cfg_data[8:0];
          CFG_INIT_EST: begin
            init_est_q = cfg_data;
            for (int i = 0; i < NT; i++) begin
              pred_burst[i] = cfg_data;
              est_ok[i] = 0;
            end
          end
          CFG_NTASKS:  ntasks_q = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(schedule_event(func, task_id));
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the scheduler testbench: clock, reset, event and config stimulus, verdict.
module tb import tsfrs_pkg::*;;

  logic              clk = 0;
  logic              rst = 1;
  logic              in_valid = 0;
  logic              in_ready;
  logic [1:0]        func = FN_READY;
  logic [3:0]        task_id = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic              running_valid;
  logic [3:0]        running_task;
  logic              dispatched;
  logic              preempted;
  logic [3:0]        preempted_task;
  logic              all_exited;
  logic              rejected;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = CFG_MODE;
  logic [BW-1:0]     cfg_data = '0;
  int                pending;
  int                errors;
  int                burst_left = 0;
  bit                steady = 0;

  always #1 clk = ~clk;

  task_scheduler_fifo_rr_sjf_unit dut (.*);

  tsfrs_checker u_checker (.*);

  // Write one register; only called while the scheduler is idle
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [BW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Offer one event item, inserting a gap between bursts unless in steady mode
  task automatic send_event(logic [1:0] f, logic [3:0] tid);
    if (burst_left == 0) begin
      burst_left = steady ? 1000 : $urandom_range(1, 20);
      if (!steady) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    func <= f;
    task_id <= tid;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold until every outstanding result has arrived
  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: changing stall patterns plus two long hold-offs
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 8000 || cyc == 40000) begin
        out_ready <= 0;
        repeat (500) @(posedge clk);
        cyc++;
      end else begin
        case ((cyc / 256) % 3)
          0: out_ready <= 1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus: directed events, then random phases under several settings
  initial begin
    int r;
    logic [1:0] f;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // no runner yet: tick, block and exit are refused
    send_event(FN_TICK, 4'd3);
    send_event(FN_BLOCK, 4'd0);
    send_event(FN_EXIT, 4'd0);
    send_event(FN_READY, 4'd15);
    send_event(FN_READY, 4'd15);
    send_event(FN_READY, 4'd0);
    send_event(FN_READY, 4'd5);
    send_event(FN_TICK, 4'd0);
    send_event(FN_BLOCK, 4'd0);
    send_event(FN_READY, 4'd15);
    send_event(FN_EXIT, 4'd0);
    send_event(FN_READY, 4'd0);
    send_event(FN_TICK, 4'd10);
    send_event(FN_TICK, 4'd5);
    drain();
    // all-exited check over task 0 alone, then over no task
    write_reg(CFG_NTASKS, 24'd1);
    send_event(FN_TICK, 4'd0);
    drain();
    write_reg(CFG_NTASKS, 24'd0);
    send_event(FN_TICK, 4'd0);
    drain();
    // round robin with a one-tick quantum, including requeue of a lone runner
    write_reg(CFG_MODE, 24'(MODE_RR));
    write_reg(CFG_QUANTUM, 24'd1);
    send_event(FN_TICK, 4'd0);
    send_event(FN_BLOCK, 4'd0);
    send_event(FN_TICK, 4'd0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_MODE, 24'(p % 4));
      case (p % 4)
        0: write_reg(CFG_QUANTUM, 24'd255);
        1: write_reg(CFG_QUANTUM, 24'd1 + (p == 5 ? 24'd2 : 24'd0));
        default: write_reg(CFG_QUANTUM, 24'($urandom_range(1, 255)));
      endcase
      case (p)
        0, 3: write_reg(CFG_ALPHA, 24'd0);
        1, 6: write_reg(CFG_ALPHA, 24'd256);
        2:    write_reg(CFG_ALPHA, 24'd511);
        default: write_reg(CFG_ALPHA, 24'($urandom_range(0, 256)));
      endcase
      case (p)
        3:    write_reg(CFG_INIT_EST, 24'hFFFFFF);
        4:    write_reg(CFG_INIT_EST, 24'd0);
        default: write_reg(CFG_INIT_EST, 24'($urandom_range(0, 4095)));
      endcase
      case (p)
        1:    write_reg(CFG_NTASKS, 24'd31);
        2:    write_reg(CFG_NTASKS, 24'd16);
        default: write_reg(CFG_NTASKS, 24'($urandom_range(1, 16)));
      endcase
      steady = (p == 2 || p == 6);
      for (int k = 0; k < 250; k++) begin
        r = $urandom_range(0, 999);
        if (r < 350)      f = FN_READY;
        else if (r < 830) f = FN_TICK;
        else if (r < 995) f = FN_BLOCK;
        else              f = FN_EXIT;
        send_event(f, 4'($urandom_range(0, 15)));
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
